>>> design/ca2_pkg.sv
// shared types, constants and the arctangent table for the cordic atan2 block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ca2_pkg;

    // field widths fixed by the interface
    localparam int IN_W  = 16;
    localparam int OUT_W = 17;

    // rotation count and table length
    localparam int ITERATIONS = 13;
    localparam int TABLE_LEN  = 13;
    localparam int STAGES     = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

    // datapath widths: folded magnitude 2^15, times sqrt2 and cordic gain, fits 20 bits
    localparam int DATA_W = 20;
    localparam int ACC_W  = 16;
    localparam int RES_W  = 18;

    // angle constants, 32768 is a full turn
    localparam logic signed [RES_W-1:0] HALF_TURN = RES_W'(16384);
    localparam logic signed [RES_W-1:0] FULL_TURN = RES_W'(32768);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // quadrant codes
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // one folded vector on its way to the rotation pipeline
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [1:0]               quad;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // atan(2^-k) scaled so that 32768 is a full turn
    function automatic logic signed [ACC_W-1:0] stage_angle(input int k);
        logic signed [ACC_W-1:0] a;
        unique case (k)
            0:       a = ACC_W'(4096);
            1:       a = ACC_W'(2418);
            2:       a = ACC_W'(1278);
            3:       a = ACC_W'(649);
            4:       a = ACC_W'(326);
            5:       a = ACC_W'(163);
            6:       a = ACC_W'(81);
            7:       a = ACC_W'(41);
            8:       a = ACC_W'(20);
            9:       a = ACC_W'(10);
            10:      a = ACC_W'(5);
            11:      a = ACC_W'(3);
            12:      a = ACC_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> design/ca2_front.sv
// front end: takes a command beat, folds the vector into the first quadrant
// depends on ca2_pkg
`timescale 1ns / 1ps
`default_nettype none

module ca2_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire  logic signed [ca2_pkg::IN_W-1:0] i_vec_y,
    input  wire  logic signed [ca2_pkg::IN_W-1:0] i_vec_x,
    output logic                                o_busy,
    input  wire                                 i_q_full,
    output logic                                o_q_push,
    output ca2_pkg::t_item                      o_q_item
);
    import ca2_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   accept;

    // fold and classify
    always_comb begin
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        x = DATA_W'(i_vec_x);
        y = DATA_W'(i_vec_y);
        n_item.x    = x;
        n_item.y    = y;
        n_item.quad = QUAD_I;
        priority if (!x[DATA_W-1] && !y[DATA_W-1]) begin
            n_item.quad = QUAD_I;
        end else if (x[DATA_W-1] && !y[DATA_W-1]) begin
            n_item.quad = QUAD_II;
            n_item.x    = -x;
        end else if (x[DATA_W-1]) begin
            n_item.quad = QUAD_III;
            n_item.x    = -x;
            n_item.y    = -y;
        end else begin
            n_item.quad = QUAD_IV;
            n_item.y    = -y;
        end
    end

    assign o_q_push = r_valid && !i_q_full;
    assign o_busy   = r_valid && i_q_full;
    assign accept   = i_start && !o_busy;
    assign o_q_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> design/ca2_queue.sv
// short queue of folded vectors between front end and rotation pipeline
// depends on ca2_pkg
`timescale 1ns / 1ps
`default_nettype none

module ca2_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  ca2_pkg::t_item  i_item,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output ca2_pkg::t_item  o_item
);
    import ca2_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // count stays within depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> design/ca2_back.sv
// back end: unrolled cordic vectoring pipeline and quadrant mapping
// depends on ca2_pkg
`timescale 1ns / 1ps
`default_nettype none

module ca2_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_q_empty,
    input  ca2_pkg::t_item                      i_q_item,
    output logic                                o_q_pop,
    output logic                                o_strobe,
    output logic signed [ca2_pkg::OUT_W-1:0]    o_angle_out
);
    import ca2_pkg::*;

    // stage registers, index k holds the vector after k rotations
    logic                     r_vld  [STAGES+1];
    logic signed [DATA_W-1:0] r_sx   [STAGES+1];
    logic signed [DATA_W-1:0] r_sy   [STAGES+1];
    logic signed [ACC_W-1:0]  r_acc  [STAGES+1];
    logic [1:0]               r_quad [STAGES+1];

    // next values of each rotation stage
    logic signed [DATA_W-1:0] n_sx   [STAGES];
    logic signed [DATA_W-1:0] n_sy   [STAGES];
    logic signed [ACC_W-1:0]  n_acc  [STAGES];

    logic                     r_strobe;
    logic signed [OUT_W-1:0]  r_angle;
    logic signed [RES_W-1:0]  n_res;

    // pipeline never stalls, so take whatever is queued
    assign o_q_pop = !i_q_empty;

    // rotate toward the x axis by the sign of y
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (r_sy[k][DATA_W-1]) begin
                n_sx[k]  = r_sx[k] - (r_sy[k] >>> k);
                n_sy[k]  = r_sy[k] + (r_sx[k] >>> k);
                n_acc[k] = r_acc[k] + stage_angle(k);
            end else begin
                n_sx[k]  = r_sx[k] + (r_sy[k] >>> k);
                n_sy[k]  = r_sy[k] - (r_sx[k] >>> k);
                n_acc[k] = r_acc[k] - stage_angle(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= o_q_pop;
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sx[0]   <= i_q_item.x;
            r_sy[0]   <= i_q_item.y;
            r_acc[0]  <= '0;
            r_quad[0] <= i_q_item.quad;
        end
        for (int k = 0; k < STAGES; k++) begin
            r_sx[k+1]   <= n_sx[k];
            r_sy[k+1]   <= n_sy[k];
            r_acc[k+1]  <= n_acc[k];
            r_quad[k+1] <= r_quad[k];
        end
    end

    // map the accumulated angle back by quadrant
    always_comb begin
        logic signed [RES_W-1:0] acc;
        acc = RES_W'(r_acc[STAGES]);
        unique case (r_quad[STAGES])
            QUAD_I:   n_res = -acc;
            QUAD_II:  n_res = HALF_TURN + acc;
            QUAD_III: n_res = HALF_TURN - acc;
            QUAD_IV:  n_res = FULL_TURN + acc;
            default:  n_res = -acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_res[OUT_W-1:0];
    end

    assign o_strobe    = r_strobe;
    assign o_angle_out = r_angle;

    // an item leaving the queue reaches the output after all stages
    a_pop_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> ##(STAGES + 2) o_strobe)
        else $error("popped beat did not reach output");

endmodule

`default_nettype wire

>>> design/cordic_atan2.sv
// top level of the cordic four-quadrant arctangent block
// depends on ca2_pkg, ca2_front, ca2_queue, ca2_back
`timescale 1ns / 1ps
`default_nettype none

// cordic_atan2: angle of the vector (x, y), 32768 is one full turn
//
// command channel: a beat is taken at a rising edge where start is high
// and busy is low; i_vec_x and i_vec_y are sampled at that edge
// result channel: o_strobe is high for one cycle with o_angle_out; the
// result is taken at the edge ending that cycle and cannot be held off
//
// front end folds the vector into the first quadrant and notes which
// quadrant it came from, a two-entry queue follows, then a 13-stage
// shift-add rotation pipeline and a quadrant mapping register
//
// throughput: one beat per cycle; the pipeline never stalls and drains
// the queue every cycle, so busy stays low in normal use
// path: the front register takes the beat at the accepting edge, then the
// queue write, pipeline entry register, 13 rotation stages and output
// register follow; the strobe rises as the output register is written
//
// reset clears the front valid, queue pointers and stage valid bits;
// beats in flight are dropped and no strobe comes until new beats arrive
// (0,0) gives 9091; results near the axes may fall just outside 0..32768
module cordic_atan2 (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    input  wire  logic signed [ca2_pkg::IN_W-1:0] i_vec_y,
    input  wire  logic signed [ca2_pkg::IN_W-1:0] i_vec_x,
    output logic                                  busy,
    output logic                                  o_strobe,
    output logic signed [ca2_pkg::OUT_W-1:0]      o_angle_out
);
    import ca2_pkg::*;

    // front to queue
    logic   q_push;
    logic   q_full;
    t_item  q_in_item;

    // queue to back
    logic   q_pop;
    logic   q_empty;
    t_item  q_out_item;

    ca2_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_vec_y  (i_vec_y),
        .i_vec_x  (i_vec_x),
        .o_busy   (busy),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in_item)
    );

    ca2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    ca2_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_strobe    (o_strobe),
        .o_angle_out (o_angle_out)
    );

    // accepting edge to the edge that takes the result
    localparam int LATENCY = STAGES + 4;

    // every accepted beat yields a strobe a fixed time later
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted beat produced no result");

    // no strobe without a beat accepted that long ago
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without matching beat");

endmodule

`default_nettype wire
